@@ hdl/vze_pkg.sv @@
// Shared types and constants for the varint/zigzag encoder.
`timescale 1ns / 1ps
`default_nettype none
package vze_pkg;

   // request kinds
   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_ZIGZAG   = 2'd1;
   localparam logic [1:0] KIND_KEY      = 2'd2;

   localparam int unsigned CODE_W    = 32;
   localparam int unsigned GROUP_W   = 7;
   localparam int unsigned MAX_BYTES = 5;
   localparam int unsigned NBYTES_W  = 3;

   localparam logic [7:0] MORE_BIT = 8'h80;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] data_value;
      logic [28:0] field_id;
      logic [2:0]  wire_type;
   } vze_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } vze_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [NBYTES_W-1:0] nbytes;
   } vze_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } vze_q_status_type;

endpackage
`default_nettype wire

@@ hdl/vze_front.sv @@
// Front end: maps a request to its 32-bit code and byte count.
`timescale 1ns / 1ps
`default_nettype none
module vze_front (
   input  wire  vze_pkg::vze_req_type      req_data,
   input  wire                             req_valid,
   input  wire  vze_pkg::vze_q_status_type q_status,
   output logic                            req_stall,
   output logic                            push,
   output vze_pkg::vze_item_type           item
);

   logic [vze_pkg::CODE_W-1:0] code;
   logic                       kind_ok;

   always_comb begin
      kind_ok = 1'b1;
      code    = '0;
      case (req_data.req_type)
         vze_pkg::KIND_UNSIGNED: begin
            code = req_data.data_value;
         end
         vze_pkg::KIND_ZIGZAG: begin
            code = {req_data.data_value[30:0], 1'b0} ^ {32{req_data.data_value[31]}};
         end
         vze_pkg::KIND_KEY: begin
            code = {req_data.field_id, req_data.wire_type};
         end
         default: begin
            // unused kind: request is consumed, nothing queued
            kind_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (code[31:28] != '0) begin
         item.nbytes = 3'd5;
      end else if (code[27:21] != '0) begin
         item.nbytes = 3'd4;
      end else if (code[20:14] != '0) begin
         item.nbytes = 3'd3;
      end else if (code[13:7] != '0) begin
         item.nbytes = 3'd2;
      end else begin
         item.nbytes = 3'd1;
      end
      item.code = code;
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && kind_ok;

endmodule
`default_nettype wire

@@ hdl/vze_queue.sv @@
// Small register FIFO between front and back.
`timescale 1ns / 1ps
`default_nettype none
module vze_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             push,
   input  wire  vze_pkg::vze_item_type     push_item,
   input  wire                             pop,
   output vze_pkg::vze_item_type           head_item,
   output vze_pkg::vze_q_status_type       status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   vze_pkg::vze_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/vze_back.sv @@
// Back end: shifts a queued code out as varint bytes into the output register.
`timescale 1ns / 1ps
`default_nettype none
module vze_back (
   input  wire                             clock,
   input  wire                             reset,
   input  wire  vze_pkg::vze_item_type     head_item,
   input  wire  vze_pkg::vze_q_status_type q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output vze_pkg::vze_rsp_type            rsp_data
);

   logic [vze_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [vze_pkg::NBYTES_W-1:0] left_ff, left_in;
   logic                         valid_ff, valid_in;
   vze_pkg::vze_rsp_type         rsp_ff, rsp_in;
   logic                         slot_free;

   // output register can take a new byte
   assign slot_free = !valid_ff || !rsp_stall;
   assign pop       = slot_free && (left_ff == '0) && !q_status.empty;

   always_comb begin
      code_in  = code_ff;
      left_in  = left_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (slot_free) begin
         if (left_ff != '0) begin
            rsp_in.out_byte  = {left_ff > 3'd1, code_ff[6:0]};
            rsp_in.last_byte = (left_ff == 3'd1);
            code_in          = code_ff >> vze_pkg::GROUP_W;
            left_in          = left_ff - 1'b1;
            valid_in         = 1'b1;
         end else if (!q_status.empty) begin
            rsp_in.out_byte  = {head_item.nbytes > 3'd1, head_item.code[6:0]};
            rsp_in.last_byte = (head_item.nbytes == 3'd1);
            code_in          = head_item.code >> vze_pkg::GROUP_W;
            left_in          = head_item.nbytes - 1'b1;
            valid_in         = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rsp_ff.last_byte == !(rsp_ff.out_byte[7])))
      else $error("last flag disagrees with continuation bit");

   a_pending_shown: assert property (@(posedge clock) disable iff (reset)
      (left_ff != '0) |-> (valid_ff && !rsp_ff.last_byte))
      else $error("bytes pending behind a final or empty output");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 3'(vze_pkg::MAX_BYTES - 1))
      else $error("pending byte count out of range");

   a_no_pop_midword: assert property (@(posedge clock) disable iff (reset)
      (left_ff != '0) |-> !pop)
      else $error("queue popped while an item is still being sent");

endmodule
`default_nettype wire

@@ hdl/varint_zigzag_encoder.sv @@
// Top level of the base-128 varint encoder with zigzag and field-key modes.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries an unsigned value, a signed value (zigzag mapped) or a
// field key ((field_id << 3) | wire_type); the block returns its varint bytes,
// low 7 bits first, bit 7 set on all but the last, which also has last_byte.
// An item yields 1 to 5 response bytes at one byte per cycle while rsp_stall is
// low; an item holds the byte serializer until its last byte is loaded.
// Requests are classified on acceptance and queued (QUEUE_DEPTH entries), so
// requests keep flowing while the serializer or the response side is busy.
// Requests with the unused kind code are accepted and yield no bytes.
module varint_zigzag_encoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  vze_pkg::vze_req_type  req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output vze_pkg::vze_rsp_type        rsp_data
);

   vze_pkg::vze_item_type     front_item;
   vze_pkg::vze_item_type     head_item;
   vze_pkg::vze_q_status_type q_status;
   logic                      push;
   logic                      pop;

   vze_front u_front (
      .req_data  (req_data),
      .req_valid (req_valid),
      .q_status  (q_status),
      .req_stall (req_stall),
      .push      (push),
      .item      (front_item)
   );

   vze_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   vze_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
